[rtl/fot_pkg.sv]
// Package for the frame ownership tracker.
// Holds command and status codes, register indexes and field widths.
// No dependencies; imported by frame_ownership_tracker_unit and tb.
package fot_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned FRAME_W = 4;
  localparam int unsigned AGENT_W = 3;
  localparam int unsigned SET_W   = 8;
  localparam int unsigned CIDX_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PROD_RELEASE = 3'd0,
    CMD_CONS_RELEASE = 3'd1,
    CMD_PROD_QUERY   = 3'd2,
    CMD_CONS_QUERY   = 3'd3,
    CMD_CONS_UNREG   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_REG    = 2'd1,
    ST_DOUBLE_REL = 2'd2,
    ST_SHUTDOWN   = 2'd3
  } status_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_PRODUCER_SET = 2'd0,
    CFG_CONSUMER_SET = 2'd1,
    CFG_SHUTDOWN     = 2'd2
  } cfg_idx_t;

  typedef logic [SET_W-1:0] agent_set_t;

endpackage

[rtl/frame_ownership_tracker_unit.sv]
// Frame ownership tracker: full/done bits per frame, release and query commands.
// Depends on fot_pkg (codes, widths, types).
// Single module: input register, one pass of logic, result register.
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  -------------------------
//  command   start, busy, in_command, in_frame, in_agent  taken when start && !busy
//  result    out_valid, out_ready_res, out_became_full,   one-cycle strobe, no stall
//            out_became_empty, out_status
//  config    cfg_we, cfg_index, cfg_wdata                 written when cfg_we
//
// One command per cycle; each result passes the input register, then the state update
// and the result register.
// busy stays low: all per-frame bits sit in flops and are updated in that one pass.
// Synchronous active-low reset clears all frame bits and loads the register defaults.
// The receiver cannot stall; every command yields exactly one result strobe.
module frame_ownership_tracker_unit #(
  parameter int FRAME_COUNT = 16,
  parameter int MAX_AGENTS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [fot_pkg::CMD_W-1:0]    in_command,
  input  logic [fot_pkg::FRAME_W-1:0]  in_frame,
  input  logic [fot_pkg::AGENT_W-1:0]  in_agent,
  output logic                         out_valid,
  output logic                         out_ready_res,
  output logic                         out_became_full,
  output logic                         out_became_empty,
  output fot_pkg::status_t             out_status,
  input  logic                         cfg_we,
  input  logic [fot_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [fot_pkg::SET_W-1:0]    cfg_wdata
);
  import fot_pkg::*;

  // Only the first sixteen frames can ever be addressed; the rest stay empty
  localparam int FRAMES_STORED =
    (FRAME_COUNT < (1 << FRAME_W)) ? FRAME_COUNT : (1 << FRAME_W);
  localparam int FI_W          = (FRAMES_STORED > 1) ? $clog2(FRAMES_STORED) : 1;
  localparam agent_set_t AGENT_MASK =
    (MAX_AGENTS >= SET_W) ? {SET_W{1'b1}} : SET_W'((9'd1 << MAX_AGENTS) - 9'd1);

  // Input register
  logic                 valid_r;
  logic [CMD_W-1:0]     cmd_r;
  logic [FRAME_W-1:0]   frame_r;
  logic [AGENT_W-1:0]   agent_r;

  // Tracker state
  logic                 frame_full_r [FRAMES_STORED];
  agent_set_t           prod_done_r  [FRAMES_STORED];
  agent_set_t           cons_done_r  [FRAMES_STORED];
  logic                 frame_full_nxt [FRAMES_STORED];
  agent_set_t           prod_done_nxt  [FRAMES_STORED];
  agent_set_t           cons_done_nxt  [FRAMES_STORED];
  agent_set_t           producer_set_r, producer_set_nxt;
  agent_set_t           active_cons_r, active_cons_nxt;
  logic                 shutdown_r, shutdown_nxt;

  // Result register
  logic                 out_valid_r;
  logic                 ready_r, ready_nxt;
  logic                 full_r, full_nxt;
  logic                 empty_r, empty_nxt;
  status_t              status_r, status_nxt;

  // Working signals for the selected frame
  logic                 in_range;
  logic [FI_W-1:0]      fidx;
  agent_set_t           abit, pset, cset, cset_unreg;
  logic                 sel_full, sel_full_new, sel_wr, unreg_do;
  agent_set_t           sel_pd, sel_cd, sel_pd_new, sel_cd_new, pd_or, cd_or;

  assign busy = 1'b0;

  // Capture a command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= start && !busy;
    end
    cmd_r   <= in_command;
    frame_r <= in_frame;
    agent_r <= in_agent;
  end

  // Decode and next state
  always_comb begin
    in_range   = (32'(frame_r) < 32'(FRAME_COUNT));
    fidx       = frame_r[FI_W-1:0];
    abit       = (SET_W'(1) << agent_r) & AGENT_MASK;
    pset       = producer_set_r & AGENT_MASK;
    cset       = active_cons_r & AGENT_MASK;
    cset_unreg = cset & ~abit;

    sel_full = in_range ? frame_full_r[fidx] : 1'b0;
    sel_pd   = in_range ? prod_done_r[fidx]  : '0;
    sel_cd   = in_range ? cons_done_r[fidx]  : '0;
    pd_or    = sel_pd | abit;
    cd_or    = sel_cd | abit;

    sel_full_new = sel_full;
    sel_pd_new   = sel_pd;
    sel_cd_new   = sel_cd;
    sel_wr       = 1'b0;
    unreg_do     = 1'b0;

    ready_nxt  = 1'b0;
    full_nxt   = 1'b0;
    empty_nxt  = 1'b0;
    status_nxt = ST_OK;

    producer_set_nxt = producer_set_r;
    active_cons_nxt  = active_cons_r;
    shutdown_nxt     = shutdown_r;

    if (valid_r && (in_range || cmd_r == CMD_CONS_UNREG)) begin
      unique case (cmd_r)
        CMD_PROD_RELEASE: begin
          if ((pset & abit) == '0) begin
            status_nxt = ST_NOT_REG;
          end else if ((sel_pd & abit) != '0) begin
            status_nxt = ST_DOUBLE_REL;
          end else begin
            sel_wr     = 1'b1;
            sel_pd_new = pd_or;
            if ((pd_or & pset) == pset) begin
              sel_pd_new   = '0;
              sel_full_new = 1'b1;
              full_nxt     = 1'b1;
              // no consumer outstanding: drop straight back to empty
              if ((sel_cd & cset) == cset) begin
                sel_full_new = 1'b0;
                sel_cd_new   = '0;
                empty_nxt    = 1'b1;
              end
            end
          end
        end
        CMD_CONS_RELEASE: begin
          if ((cset & abit) == '0) begin
            status_nxt = ST_NOT_REG;
          end else begin
            sel_wr     = 1'b1;
            sel_cd_new = cd_or;
            if ((cd_or & cset) == cset) begin
              sel_full_new = 1'b0;
              sel_cd_new   = '0;
              empty_nxt    = 1'b1;
            end
          end
        end
        CMD_PROD_QUERY: begin
          if ((pset & abit) == '0) begin
            status_nxt = ST_NOT_REG;
          end else if (shutdown_r) begin
            status_nxt = ST_SHUTDOWN;
          end else begin
            ready_nxt = !sel_full && ((sel_pd & abit) == '0);
          end
        end
        CMD_CONS_QUERY: begin
          if ((cset & abit) == '0) begin
            status_nxt = ST_NOT_REG;
          end else if (shutdown_r) begin
            status_nxt = ST_SHUTDOWN;
          end else begin
            ready_nxt = sel_full && ((sel_cd & abit) == '0);
          end
        end
        CMD_CONS_UNREG: begin
          if ((cset & abit) == '0) begin
            status_nxt = ST_NOT_REG;
          end else begin
            unreg_do        = 1'b1;
            active_cons_nxt = active_cons_r & ~abit;
          end
        end
        default: begin
          // unknown command: all-zero result, no change
        end
      endcase
    end

    // Per-frame update; unregister sweeps every frame in parallel
    for (int f = 0; f < FRAMES_STORED; f++) begin
      frame_full_nxt[f] = frame_full_r[f];
      prod_done_nxt[f]  = prod_done_r[f];
      cons_done_nxt[f]  = cons_done_r[f];
      if (sel_wr && fidx == FI_W'(f)) begin
        frame_full_nxt[f] = sel_full_new;
        prod_done_nxt[f]  = sel_pd_new;
        cons_done_nxt[f]  = sel_cd_new;
      end
      if (unreg_do) begin
        cons_done_nxt[f] = cons_done_r[f] & ~abit;
        if ((cons_done_nxt[f] & cset_unreg) == cset_unreg) begin
          frame_full_nxt[f] = 1'b0;
          cons_done_nxt[f]  = '0;
          empty_nxt         = 1'b1;
        end
      end
    end

    // Register writes (user must write only while idle; the block does not enforce it); stale done bits are pruned
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRODUCER_SET: begin
          producer_set_nxt = cfg_wdata;
          for (int f = 0; f < FRAMES_STORED; f++) begin
            prod_done_nxt[f] = prod_done_r[f] & cfg_wdata;
          end
        end
        CFG_CONSUMER_SET: begin
          active_cons_nxt = cfg_wdata;
          for (int f = 0; f < FRAMES_STORED; f++) begin
            cons_done_nxt[f] = cons_done_r[f] & cfg_wdata;
          end
        end
        CFG_SHUTDOWN: begin
          shutdown_nxt = cfg_wdata[0];
        end
        default: begin
          // index beyond the register list: ignored
        end
      endcase
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < FRAMES_STORED; f++) begin
        frame_full_r[f] <= 1'b0;
        prod_done_r[f]  <= '0;
        cons_done_r[f]  <= '0;
      end
      producer_set_r <= SET_W'(1);
      active_cons_r  <= SET_W'(1);
      shutdown_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      frame_full_r   <= frame_full_nxt;
      prod_done_r    <= prod_done_nxt;
      cons_done_r    <= cons_done_nxt;
      producer_set_r <= producer_set_nxt;
      active_cons_r  <= active_cons_nxt;
      shutdown_r     <= shutdown_nxt;
      out_valid_r    <= valid_r;
    end
    ready_r  <= ready_nxt;
    full_r   <= full_nxt;
    empty_r  <= empty_nxt;
    status_r <= status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_ready_res    = ready_r;
  assign out_became_full  = full_r;
  assign out_became_empty = empty_r;
  assign out_status       = status_r;

`ifndef SYNTHESIS
  // every accepted command produces a result once it has passed both registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted command produced no result");

  // a positive query answer only comes with ok status
  a_ready_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready_res) |-> (out_status == ST_OK))
    else $error("ready reported with error status");

  // an error leaves no fill or empty event
  a_err_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (!out_became_full && !out_became_empty))
    else $error("event flagged on an errored command");

  // active consumers only gain members through a register write
  a_active_no_gain: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> ((active_cons_r & ~$past(active_cons_r)) == '0))
    else $error("active consumer set grew without a write");
`endif

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for frame_ownership_tracker_unit: directed and random commands,
// results predicted in-bench and compared field by field as each strobe arrives.
// Depends on fot_pkg and the frame_ownership_tracker_unit RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fot_pkg::*;

  localparam int FRAME_COUNT   = 16;
  localparam int MAX_AGENTS    = 8;
  localparam int DRAIN_CYCLES  = 4;
  localparam int RANDOM_PHASES = 14;
  localparam int RANDOM_ITEMS  = 1880;
  localparam int TIMEOUT_NS    = 2_000_000;
  localparam logic [CMD_W-1:0] CMD_CODE_MAX = '1;

  typedef struct packed {
    logic    ready;
    logic    full;
    logic    empty;
    status_t status;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     in_command = '0;
  logic [FRAME_W-1:0]   in_frame = '0;
  logic [AGENT_W-1:0]   in_agent = '0;
  logic                 out_valid;
  logic                 out_ready_res;
  logic                 out_became_full;
  logic                 out_became_empty;
  status_t              out_status;
  logic                 cfg_we = 1'b0;
  logic [CIDX_W-1:0]    cfg_index = '0;
  logic [SET_W-1:0]     cfg_wdata = '0;

  // Shadow copy of the tracker state and registers
  logic       frame_full_q  [FRAME_COUNT] = '{default: 1'b0};
  agent_set_t prod_done_q   [FRAME_COUNT] = '{default: '0};
  agent_set_t cons_done_q   [FRAME_COUNT] = '{default: '0};
  agent_set_t prod_set_q    = 8'h01;
  agent_set_t cons_active_q = 8'h01;
  logic       shutdown_q    = 1'b0;

  outcome_t         pending_outcomes[$];
  logic [AGENT_W-1:0] agent_order [MAX_AGENTS];
  int unsigned      sent_count = 0;
  int unsigned      burst_left = 0;
  int unsigned      mismatch_count = 0;

  frame_ownership_tracker_unit #(
    .FRAME_COUNT(FRAME_COUNT),
    .MAX_AGENTS(MAX_AGENTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_frame(in_frame),
    .in_agent(in_agent),
    .out_valid(out_valid),
    .out_ready_res(out_ready_res),
    .out_became_full(out_became_full),
    .out_became_empty(out_became_empty),
    .out_status(out_status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Frame drains once every active consumer has finished with it
  function automatic logic cons_all_done(input int fr);
    return (cons_done_q[fr] & cons_active_q) == cons_active_q;
  endfunction

  function automatic void clear_frame(input int fr);
    frame_full_q[fr] = 1'b0;
    cons_done_q[fr]  = '0;
  endfunction

  // Advance the shadow state by one command and return the outcome it yields
  function automatic outcome_t predict_outcome(input logic [CMD_W-1:0] cmd,
                                               input logic [FRAME_W-1:0] fr,
                                               input logic [AGENT_W-1:0] ag);
    outcome_t   o;
    agent_set_t sel;
    o = '0;
    o.status = ST_OK;
    sel = agent_set_t'(1) << ag;
    unique case (cmd)
      CMD_PROD_RELEASE: begin
        if ((prod_set_q & sel) == '0) begin
          o.status = ST_NOT_REG;
        end else if ((prod_done_q[fr] & sel) != '0) begin
          o.status = ST_DOUBLE_REL;
        end else begin
          prod_done_q[fr] |= sel;
          if ((prod_done_q[fr] & prod_set_q) == prod_set_q) begin
            prod_done_q[fr]  = '0;
            frame_full_q[fr] = 1'b1;
            o.full = 1'b1;
            // nobody left to read it: straight back to empty
            if (cons_all_done(fr)) begin
              clear_frame(fr);
              o.empty = 1'b1;
            end
          end
        end
      end
      CMD_CONS_RELEASE: begin
        if ((cons_active_q & sel) == '0) begin
          o.status = ST_NOT_REG;
        end else begin
          cons_done_q[fr] |= sel;
          if (cons_all_done(fr)) begin
            clear_frame(fr);
            o.empty = 1'b1;
          end
        end
      end
      CMD_PROD_QUERY: begin
        if ((prod_set_q & sel) == '0) o.status = ST_NOT_REG;
        else if (shutdown_q) o.status = ST_SHUTDOWN;
        else o.ready = !frame_full_q[fr] && ((prod_done_q[fr] & sel) == '0);
      end
      CMD_CONS_QUERY: begin
        if ((cons_active_q & sel) == '0) o.status = ST_NOT_REG;
        else if (shutdown_q) o.status = ST_SHUTDOWN;
        else o.ready = frame_full_q[fr] && ((cons_done_q[fr] & sel) == '0);
      end
      CMD_CONS_UNREG: begin
        if ((cons_active_q & sel) == '0) begin
          o.status = ST_NOT_REG;
        end else begin
          cons_active_q &= ~sel;
          for (int f = 0; f < FRAME_COUNT; f++) begin
            cons_done_q[f] &= ~sel;
            if (cons_all_done(f)) begin
              clear_frame(f);
              o.empty = 1'b1;
            end
          end
        end
      end
      default: ;  // unused codes leave everything alone
    endcase
    return o;
  endfunction

  // Register writes also mask done bits of agents that drop out
  function automatic void apply_register(input cfg_idx_t idx, input agent_set_t val);
    unique case (idx)
      CFG_PRODUCER_SET: begin
        prod_set_q = val;
        for (int f = 0; f < FRAME_COUNT; f++) prod_done_q[f] &= val;
      end
      CFG_CONSUMER_SET: begin
        cons_active_q = val;
        for (int f = 0; f < FRAME_COUNT; f++) cons_done_q[f] &= val;
      end
      CFG_SHUTDOWN: shutdown_q = val[0];
      default: ;
    endcase
  endfunction

  task automatic pause_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // One command transaction; sender works in bursts with random gaps
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [FRAME_W-1:0] fr,
                           input logic [AGENT_W-1:0] ag);
    outcome_t expected;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
    burst_left--;
    start      <= 1'b1;
    in_command <= cmd;
    in_frame   <= fr;
    in_agent   <= ag;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    expected = predict_outcome(cmd, fr, ag);
    pending_outcomes = {pending_outcomes, expected};
    sent_count++;
  endtask

  // Register write, only once the tracker has gone quiet
  task automatic write_reg(input cfg_idx_t idx, input agent_set_t val);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_register(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic shuffle_order();
    int unsigned        j;
    logic [AGENT_W-1:0] tmp;
    for (int i = 0; i < MAX_AGENTS; i++) agent_order[i] = AGENT_W'(i);
    for (int i = MAX_AGENTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = agent_order[i];
      agent_order[i] = agent_order[j];
      agent_order[j] = tmp;
    end
  endtask

  // Fill a frame with every registered producer, then drain it with every
  // active consumer; sometimes cut short or followed by a stray release
  task automatic run_frame_round(input logic [FRAME_W-1:0] fr);
    int unsigned steps;
    agent_set_t  members;
    steps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2 * MAX_AGENTS - 1)
                                         : 2 * MAX_AGENTS;
    shuffle_order();
    members = prod_set_q;
    for (int i = 0; i < MAX_AGENTS && steps != 0; i++) begin
      if (members[agent_order[i]]) begin
        if ($urandom_range(0, 2) == 0) send_item(CMD_PROD_QUERY, fr, agent_order[i]);
        send_item(CMD_PROD_RELEASE, fr, agent_order[i]);
        steps--;
      end
    end
    shuffle_order();
    members = cons_active_q;
    for (int i = 0; i < MAX_AGENTS && steps != 0; i++) begin
      if (members[agent_order[i]]) begin
        if ($urandom_range(0, 2) == 0) send_item(CMD_CONS_QUERY, fr, agent_order[i]);
        send_item(CMD_CONS_RELEASE, fr, agent_order[i]);
        steps--;
      end
    end
    if ($urandom_range(0, 7) == 0)
      send_item(CMD_PROD_RELEASE, fr, AGENT_W'($urandom_range(0, MAX_AGENTS - 1)));
  endtask

  // Reset defaults: one producer, one consumer
  task automatic test_single_owner();
    send_item(CMD_PROD_QUERY,   4'd0,  3'd0);
    send_item(CMD_PROD_QUERY,   4'd0,  3'd1);   // unregistered producer
    send_item(CMD_PROD_RELEASE, 4'd0,  3'd0);
    send_item(CMD_CONS_QUERY,   4'd0,  3'd0);
    send_item(CMD_PROD_RELEASE, 4'd0,  3'd0);   // release while already full
    send_item(CMD_CONS_RELEASE, 4'd0,  3'd0);
    send_item(CMD_CONS_RELEASE, 4'd15, 3'd0);   // consumer release on an empty frame
    send_item(CMD_CONS_RELEASE, 4'd15, 3'd7);
  endtask

  // Several agents on one frame, double release and unregistering
  task automatic test_shared_frame();
    write_reg(CFG_PRODUCER_SET, 8'h81);
    write_reg(CFG_CONSUMER_SET, 8'h83);
    send_item(CMD_PROD_RELEASE, 4'd15, 3'd7);
    send_item(CMD_PROD_RELEASE, 4'd15, 3'd7);   // same producer twice
    send_item(CMD_PROD_QUERY,   4'd15, 3'd7);
    send_item(CMD_PROD_RELEASE, 4'd15, 3'd0);
    send_item(CMD_CONS_RELEASE, 4'd15, 3'd1);
    send_item(CMD_CONS_QUERY,   4'd15, 3'd1);
    send_item(CMD_CONS_UNREG,   4'd15, 3'd1);
    send_item(CMD_CONS_UNREG,   4'd3,  3'd1);   // already gone
    send_item(CMD_CONS_RELEASE, 4'd15, 3'd0);
    send_item(CMD_CONS_UNREG,   4'd0,  3'd7);   // last holdout leaves, frame drains
  endtask

  // Shutdown answers on queries and codes outside the command set
  task automatic test_shutdown_and_unused();
    write_reg(CFG_SHUTDOWN, 8'h01);
    send_item(CMD_PROD_QUERY, 4'd0, 3'd0);
    send_item(CMD_CONS_QUERY, 4'd0, 3'd0);
    send_item(CMD_CONS_QUERY, 4'd0, 3'd2);      // registration checked first
    for (logic [CMD_W:0] c = (CMD_W+1)'(CMD_CONS_UNREG) + 1'b1; c <= CMD_CODE_MAX; c++)
      send_item(c[CMD_W-1:0], 4'd15, 3'd7);
    write_reg(CFG_SHUTDOWN, 8'h00);
  endtask

  // Random phases, each with its own register setting
  task automatic test_random_traffic();
    int unsigned      phase_end;
    logic [CMD_W-1:0] cmd;
    agent_set_t       pset;
    agent_set_t       cset;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pset = (p % 6 == 0) ? 8'hFF : (p % 6 == 3) ? 8'h00 : agent_set_t'($urandom_range(1, 255));
      cset = (p % 5 == 1) ? 8'hFF : (p % 5 == 4) ? 8'h00 : agent_set_t'($urandom_range(1, 255));
      write_reg(CFG_PRODUCER_SET, pset);
      write_reg(CFG_CONSUMER_SET, cset);
      write_reg(CFG_SHUTDOWN, agent_set_t'(p % 4 == 3));
      phase_end = sent_count + RANDOM_ITEMS / RANDOM_PHASES;
      while (sent_count < phase_end) begin
        if ($urandom_range(0, 9) < 7) begin
          run_frame_round(FRAME_W'($urandom_range(0, FRAME_COUNT - 1)));
        end else begin
          // noise; unregistering kept rare so the consumer set survives the phase
          cmd = CMD_W'($urandom_range(0, CMD_CODE_MAX));
          if (cmd == CMD_CONS_UNREG && $urandom_range(0, 3) != 0) cmd = CMD_CONS_QUERY;
          send_item(cmd, FRAME_W'($urandom_range(0, FRAME_COUNT - 1)),
                    AGENT_W'($urandom_range(0, MAX_AGENTS - 1)));
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [1:0] want,
                               input logic [1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result check, sampled mid-cycle while the strobe is stable
  always @(negedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, %s=%0d full=%0d empty=%0d status=%0d",
                 $time, "actual ready", out_ready_res, out_became_full, out_became_empty,
                 out_status);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        compare_field("ready_res",    want.ready,  out_ready_res);
        compare_field("became_full",  want.full,   out_became_full);
        compare_field("became_empty", want.empty,  out_became_empty);
        compare_field("status",       want.status, out_status);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_owner();
    test_shared_frame();
    test_shutdown_and_unused();
    test_random_traffic();
    start <= 1'b0;
    for (int n = 0; n < 1000 && pending_outcomes.size() != 0; n++) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_outcomes.size());
      mismatch_count += pending_outcomes.size();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
